// ----- rtl/mps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_pkg: shared types and constants of the masked pattern scanner
// Widths of the fixed fields, register indexes and the records passed
// between the cell row, the front stage and the report stage.
// ----------------------------------------------------------------------------
package mps_pkg;

   // Fixed field widths
   localparam int BYTE_W        = 8;
   localparam int PATTERN_BYTES = 8;
   localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
   localparam int SEL_W         = 3;
   localparam int LEN_W         = 4;
   localparam int ADDR_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int CSR_INDEX_W   = 3;

   // Default pattern capacity
   localparam int MAX_PATTERN_DEFAULT = 8;

   // Register reset values
   localparam logic [PATTERN_BYTES-1:0] CARE_MASK_RESET = '1;
   localparam logic [LEN_W-1:0]         PATTERN_LENGTH_RESET = 4'd4;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES  = 3'd0,
      CSR_CARE_MASK      = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_BASE_ADDRESS   = 3'd3,
      CSR_REPORT_OFFSET  = 3'd4
   } csr_index_type;

   // Control shared by every cell of the row
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   // Front stage record handed to the report stage
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] start;
      logic              last;
   } front_type;

endpackage

// ----- rtl/mps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_cell: one window cell
// Holds one byte of the sliding window, passes it to the next cell on each
// transaction and compares the byte arriving at its input against the
// pattern byte that lines up with its place for the current length.
// ----------------------------------------------------------------------------
module mps_cell
   import mps_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic [BYTE_W-1:0]        byte_in,
   input  logic [PATTERN_W-1:0]     pattern_bytes,
   input  logic [PATTERN_BYTES-1:0] care_mask,
   input  logic [LEN_W-1:0]         used_len,
   output logic [BYTE_W-1:0]        byte_out,
   output logic                     match_out
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_next;
   logic [LEN_W-1:0]  sel_full;
   logic [SEL_W-1:0]  sel;
   logic [BYTE_W-1:0] want;
   logic              active;

   // Pick the pattern byte that aligns with this cell: len - 1 - index
   always_comb begin
      active   = (LEN_W'(CELL_INDEX) < used_len);
      sel_full = used_len - LEN_W'(CELL_INDEX) - LEN_W'(1);
      sel      = sel_full[SEL_W-1:0];
      want     = pattern_bytes[sel*BYTE_W +: BYTE_W];
      // Cells beyond the pattern and wildcard positions always agree
      match_out = !active || !care_mask[sel] || (byte_in == want);
   end

   // Shift the window, drop it at the end of a region
   always_comb begin
      byte_in_next = byte_ff;
      if (ctrl.clear) begin
         byte_in_next = '0;
      end else if (ctrl.shift) begin
         byte_in_next = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

// ----- rtl/mps_report.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_report: result stage
// Forms the reported address, keeps the saturating match count and holds
// the result transaction in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mps_report
   import mps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       front_valid,
   input  front_type                  front,
   input  logic [ADDR_W-1:0]          base_address,
   input  logic [ADDR_W-1:0]          report_offset,
   output logic                       advance,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [ADDR_W+COUNT_W-1:0]  rsp_tdata,  // match_address, match_count
   output logic                       rsp_tuser,  // match_found
   output logic                       rsp_tlast   // scan_done
);

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                found_ff, found_in;
   logic                done_ff, done_in;
   logic [ADDR_W-1:0]   address_ff, address_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  occurrences_ff, occurrences_in;
   logic [COUNT_W-1:0]  count_next;
   logic                load;

   assign advance = !rsp_tvalid_ff || rsp_tready;
   assign load    = advance && front_valid;

   // Count the hit, saturating at all ones
   always_comb begin
      count_next = occurrences_ff;
      if (front.hit && (occurrences_ff != '1)) begin
         count_next = occurrences_ff + COUNT_W'(1);
      end
   end

   // Build the next result and update the count
   always_comb begin
      rsp_tvalid_in  = rsp_tvalid_ff;
      found_in       = found_ff;
      done_in        = done_ff;
      address_in     = address_ff;
      count_in       = count_ff;
      occurrences_in = occurrences_ff;
      if (advance) begin
         rsp_tvalid_in = front_valid;
      end
      if (load) begin
         found_in       = front.hit;
         done_in        = front.last;
         address_in     = front.hit ? (base_address + front.start + report_offset) : '0;
         count_in       = count_next;
         occurrences_in = front.last ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff  <= 1'b0;
         occurrences_ff <= '0;
      end else begin
         rsp_tvalid_ff  <= rsp_tvalid_in;
         occurrences_ff <= occurrences_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      done_ff    <= done_in;
      address_ff <= address_in;
      count_ff   <= count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {count_ff, address_ff};
   assign rsp_tuser  = found_ff;
   assign rsp_tlast  = done_ff;

endmodule

// ----- rtl/masked_pattern_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_pattern_scanner: masked byte pattern search over a byte stream
// Row of window cells compares each new window against a pattern with a
// per-byte care mask and reports matches with address and running count.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one memory byte per transaction in req_tdata;
//   req_tlast marks the last byte of a region.
//   rsp_ channel returns exactly one result per byte: req order is kept.
//   rsp_tuser is set when the window ending at that byte matches,
//   rsp_tdata holds the reported address (low 32 bits, zero without a match)
//   and the match count so far (high 32 bits, saturating). rsp_tlast echoes
//   the end of region; the count is then the total and window, position and
//   count start over for the next region. csr_ port writes one register per
//   cycle; the user writes only while the block is idle (unchecked).
// Path: an accepted byte's result is registered in the front register,
//   then in the output register, whose load raises rsp_tvalid.
// Throughput: one byte per cycle while req_tready is high; the cell row
//   compares all pattern bytes of a window in the cycle the byte is accepted.
// Reset: registers take their reset values, window and count clear.
// Stall: with rsp_tready low the output register holds; one more byte is
//   taken into the front register if it is empty, then req_tready drops.
// ----------------------------------------------------------------------------
module masked_pattern_scanner
   import mps_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Byte stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_W-1:0]         req_tdata,   // data_byte
   input  logic                      req_tlast,   // frame_end
   // Results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ADDR_W+COUNT_W-1:0] rsp_tdata,   // match_address, match_count
   output logic                      rsp_tuser,   // match_found
   output logic                      rsp_tlast,   // scan_done
   // Register writes
   input  logic                      csr_we,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [PATTERN_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [PATTERN_W-1:0]     pattern_bytes_ff;
   logic [PATTERN_BYTES-1:0] care_mask_ff;
   logic [LEN_W-1:0]         pattern_length_ff;
   logic [ADDR_W-1:0]        base_address_ff;
   logic [ADDR_W-1:0]        report_offset_ff;

   // Scan state
   logic [LEN_W-1:0]         fill_ff, fill_in;
   logic [LEN_W-1:0]         fill_next;
   logic [ADDR_W-1:0]        position_ff, position_in;
   logic                     front_valid_ff, front_valid_in;
   front_type                front_ff, front_in;

   logic [LEN_W-1:0]         used_len;
   logic                     accept;
   logic                     advance;
   cell_ctrl_type            cell_ctrl;
   logic [BYTE_W-1:0]        cell_in  [MAX_PATTERN];
   logic [BYTE_W-1:0]        cell_out [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]   cell_match;

   // Write configuration registers; unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         care_mask_ff      <= CARE_MASK_RESET;
         pattern_length_ff <= PATTERN_LENGTH_RESET;
         base_address_ff   <= '0;
         report_offset_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_BYTES:  pattern_bytes_ff  <= csr_wdata;
            CSR_CARE_MASK:      care_mask_ff      <= csr_wdata[PATTERN_BYTES-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_BASE_ADDRESS:   base_address_ff   <= csr_wdata[ADDR_W-1:0];
            CSR_REPORT_OFFSET:  report_offset_ff  <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the length into 1..MAX_PATTERN
   always_comb begin
      used_len = pattern_length_ff;
      if (pattern_length_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(MAX_PATTERN)) begin
         used_len = LEN_W'(MAX_PATTERN);
      end
   end

   // Input handshake
   assign req_tready      = !front_valid_ff || advance;
   assign accept          = req_tvalid && req_tready;
   assign cell_ctrl.shift = accept;
   assign cell_ctrl.clear = accept && req_tlast;

   // Row of window cells, newest byte in cell zero
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_in[k] = req_tdata;
      end else begin : g_link
         assign cell_in[k] = cell_out[k-1];
      end
      mps_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .byte_in       (cell_in[k]),
         .pattern_bytes (pattern_bytes_ff),
         .care_mask     (care_mask_ff),
         .used_len      (used_len),
         .byte_out      (cell_out[k]),
         .match_out     (cell_match[k])
      );
   end

   // Front stage: fill, position and the hit of the new window
   always_comb begin
      fill_next = fill_ff;
      if (fill_ff < LEN_W'(MAX_PATTERN)) begin
         fill_next = fill_ff + LEN_W'(1);
      end
      fill_in        = fill_ff;
      position_in    = position_ff;
      front_valid_in = front_valid_ff;
      front_in       = front_ff;
      if (advance) begin
         front_valid_in = 1'b0;
      end
      if (accept) begin
         fill_in        = req_tlast ? '0 : fill_next;
         position_in    = req_tlast ? '0 : (position_ff + ADDR_W'(1));
         front_valid_in = 1'b1;
         front_in.hit   = (fill_next >= used_len) && (&cell_match);
         front_in.start = position_ff - ADDR_W'(used_len) + ADDR_W'(1);
         front_in.last  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff        <= '0;
         position_ff    <= '0;
         front_valid_ff <= 1'b0;
      end else begin
         fill_ff        <= fill_in;
         position_ff    <= position_in;
         front_valid_ff <= front_valid_in;
      end
   end

   // Front payload holds without reset
   always_ff @(posedge clock) begin
      front_ff <= front_in;
   end

   // Result stage
   mps_report u_report (
      .clock         (clock),
      .reset         (reset),
      .front_valid   (front_valid_ff),
      .front         (front_ff),
      .base_address  (base_address_ff),
      .report_offset (report_offset_ff),
      .advance       (advance),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule
